### rtl/coincidence_time_difference_histogram_defines.svh
// Assertion macros for the coincidence time-difference histogram.
`ifndef COINCIDENCE_TIME_DIFFERENCE_HISTOGRAM_DEFINES_SVH
`define COINCIDENCE_TIME_DIFFERENCE_HISTOGRAM_DEFINES_SVH

`ifndef SYNTH

// Holds at every sampled edge out of reset.
`define CTDH_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CTDH_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CTDH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CTDH_ASSERT_ALWAYS(lbl, cond, msg)
`define CTDH_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define CTDH_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/ctdh_pkg.sv
// Shared types and constants of the coincidence time-difference histogram.
package ctdh_pkg;

	localparam int COUNT_W = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int HALF_W = 5;
	localparam logic [HALF_W-1:0] HALF_RANGE_RESET = 5'd20;

	localparam logic [31:0] MARKER_CODE = 32'h8000_0000;
	localparam logic [31:0] MASK_A      = 32'd1;
	localparam logic [31:0] MASK_B      = 32'd2;
	localparam logic [31:0] MASK_AB     = 32'd3;
	localparam logic [31:0] MASK_TRIG   = 32'd4;

	localparam logic [1:0] CLS_IN    = 2'd0;
	localparam logic [1:0] CLS_UNDER = 2'd1;
	localparam logic [1:0] CLS_OVER  = 2'd2;

	typedef enum logic [1:0] {
		ACT_RECORD = 2'd0,
		ACT_READ   = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		SEL_NONE  = 2'd0,
		SEL_BIN   = 2'd1,
		SEL_UNDER = 2'd2,
		SEL_OVER  = 2'd3
	} cnt_sel_t;

	// What one request does to the histogram.
	typedef struct packed {
		cnt_sel_t bump;
		cnt_sel_t rd;
		logic     clear;
	} hist_op_t;

endpackage

### rtl/ctdh_time_unit.sv
// Epoch and hit-time latches, trigger difference and bin classification.
module ctdh_time_unit #(
	parameter int NUM_BINS   = 64,
	parameter int EPOCH_BITS = 16,
	parameter int CLOCK_BITS = 30
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 step,
	input  logic [1:0]                           action,
	input  logic [31:0]                          record_code,
	input  logic [31:0]                          record_value,
	input  logic [ctdh_pkg::HALF_W-1:0]          half_range,
	output logic                                 diff_valid,
	output logic signed [EPOCH_BITS+CLOCK_BITS:0] delta_cycles,
	output logic [1:0]                           range_class,
	output ctdh_pkg::cnt_sel_t                   bump,
	output logic [$clog2(NUM_BINS)-1:0]          bump_addr
);
	import ctdh_pkg::*;

	localparam int TW    = EPOCH_BITS + CLOCK_BITS;
	localparam int DW    = TW + 1;
	localparam int BIN_W = $clog2(NUM_BINS);

	logic [EPOCH_BITS-1:0] epoch_q;
	logic [TW-1:0]         time_a_q, time_b_q;
	logic                  a_valid_q, b_valid_q;

	logic                  is_rec, marker, hit, lat_a, lat_b, trig;
	logic [33:0]           ep_full;
	logic [TW-1:0]         t_now;
	logic [DW-1:0]         d;
	logic                  neg, near_zero;
	logic signed [7:0]     dsm, hs, sum8;
	logic                  under, over_r, in_arr;
	logic [5:0]            bin6;
	logic [10:0]           bin_ext;
	logic [1:0]            cls;

	always_comb begin
		is_rec  = (action == ACT_RECORD);
		marker  = (record_code == MARKER_CODE);
		hit     = is_rec && !marker;
		lat_a   = hit && (record_code == MASK_A || record_code == MASK_AB);
		lat_b   = hit && (record_code == MASK_B || record_code == MASK_AB);
		trig    = hit && (record_code == MASK_TRIG) && a_valid_q && b_valid_q;
		ep_full = {2'b00, record_value} - {2'b00, MARKER_CODE};
		t_now   = {epoch_q, record_value[CLOCK_BITS-1:0]};
	end

	// Signed difference, then a narrow window check around zero.
	always_comb begin
		d      = {1'b0, time_b_q} - {1'b0, time_a_q};
		neg    = d[DW-1];
		near_zero = neg ? (&d[DW-1:6]) : ~(|d[DW-1:6]);
		dsm    = {d[6], d[6:0]};
		hs     = {3'b000, half_range};
		sum8   = dsm + hs;
		under  = neg && (!near_zero || sum8[7]);
		over_r = !neg && (!near_zero || (dsm > hs));
		bin6   = sum8[5:0];
		bin_ext = {5'b00000, bin6};
		in_arr = (bin_ext < 11'(NUM_BINS));
		if (under) begin
			cls = CLS_UNDER;
		end else if (over_r || !in_arr) begin
			cls = CLS_OVER;
		end else begin
			cls = CLS_IN;
		end
	end

	always_comb begin
		diff_valid   = trig;
		delta_cycles = trig ? $signed(d) : '0;
		range_class  = trig ? cls : CLS_IN;
		bump_addr    = bin_ext[BIN_W-1:0];
		if (!trig) begin
			bump = SEL_NONE;
		end else if (cls == CLS_UNDER) begin
			bump = SEL_UNDER;
		end else if (cls == CLS_OVER) begin
			bump = SEL_OVER;
		end else begin
			bump = SEL_BIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q   <= '0;
			time_a_q  <= '0;
			time_b_q  <= '0;
			a_valid_q <= 1'b0;
			b_valid_q <= 1'b0;
		end else if (step) begin
			if (is_rec && marker) begin
				epoch_q <= ep_full[EPOCH_BITS-1:0];
			end
			if (lat_a) begin
				time_a_q  <= t_now;
				a_valid_q <= 1'b1;
			end
			if (lat_b) begin
				time_b_q  <= t_now;
				b_valid_q <= 1'b1;
			end
		end
	end

endmodule

### rtl/ctdh_hist.sv
// Histogram store: bin memory with valid bits, underflow and overflow counters.
module ctdh_hist #(
	parameter int NUM_BINS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             ld,
	input  logic                             fire,
	input  ctdh_pkg::hist_op_t               op,
	input  logic [$clog2(NUM_BINS)-1:0]      bump_addr,
	input  logic [$clog2(NUM_BINS)-1:0]      rd_addr,
	output logic [ctdh_pkg::COUNT_W-1:0]     bin_count
);
	import ctdh_pkg::*;

	localparam int BIN_W = $clog2(NUM_BINS);

	logic [COUNT_W-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0] entry_valid_q;
	logic [COUNT_W-1:0]  under_q, over_q;

	hist_op_t            op_s2;
	logic [BIN_W-1:0]    addr_s2;
	logic [COUNT_W-1:0]  mem_rd_s2, fwd_val_s2;
	logic                fwd_s2, vld_s2;

	logic [BIN_W-1:0]    addr;
	logic [COUNT_W-1:0]  cur, wr_val;
	logic                wr_bin;

	always_comb begin
		addr   = (op.bump == SEL_BIN) ? bump_addr : rd_addr;
		cur    = fwd_s2 ? fwd_val_s2 : (vld_s2 ? mem_rd_s2 : '0);
		wr_val = (cur == COUNT_MAX) ? cur : cur + 1'b1;
		wr_bin = fire && (op_s2.bump == SEL_BIN);
	end

	always_comb begin
		case (op_s2.rd)
			SEL_BIN:   bin_count = cur;
			SEL_UNDER: bin_count = under_q;
			SEL_OVER:  bin_count = over_q;
			default:   bin_count = '0;
		endcase
	end

	// Bin memory: write the bumped count, read for the entering request.
	always_ff @(posedge clk) begin
		if (wr_bin) begin
			mem[addr_s2] <= wr_val;
		end
		if (ld) begin
			mem_rd_s2 <= mem[addr];
		end
	end

	// Read side payload; bypass a write or clear leaving on the same edge.
	always_ff @(posedge clk) begin
		if (ld) begin
			addr_s2    <= addr;
			vld_s2     <= entry_valid_q[addr];
			fwd_val_s2 <= (wr_bin && addr_s2 == addr) ? wr_val : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s2  <= '0;
			fwd_s2 <= 1'b0;
		end else if (ld) begin
			op_s2  <= op;
			fwd_s2 <= (wr_bin && addr_s2 == addr) || (fire && op_s2.clear);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			under_q       <= '0;
			over_q        <= '0;
		end else if (fire) begin
			if (op_s2.clear) begin
				entry_valid_q <= '0;
				under_q       <= '0;
				over_q        <= '0;
			end
			if (wr_bin) begin
				entry_valid_q[addr_s2] <= 1'b1;
			end
			if (op_s2.bump == SEL_UNDER && under_q != COUNT_MAX) begin
				under_q <= under_q + 1'b1;
			end
			if (op_s2.bump == SEL_OVER && over_q != COUNT_MAX) begin
				over_q <= over_q + 1'b1;
			end
		end
	end

endmodule

### rtl/coincidence_time_difference_histogram.sv
// A request is held in stage one, then moves into the result register, where it waits
// until out_ready takes it.
// Throughput: one request per cycle; a waiting result blocks intake once stage one is full.
// Bin counters are read as a request leaves stage one, bumped as its result is taken.
// Reset (arst_n low, asynchronous): latches, epoch, valid bits, counters and the histogram
// (by per-bin valid bits) go to zero, half_range_cycles to 20; config is always ready.
`include "coincidence_time_difference_histogram_defines.svh"

module coincidence_time_difference_histogram #(
	parameter int NUM_BINS   = 64,
	parameter int EPOCH_BITS = 16,
	parameter int CLOCK_BITS = 30
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ctdh_pkg::HALF_W-1:0]           half_range_cycles,
	// Request channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            action,
	input  logic [31:0]                           record_code,
	input  logic [31:0]                           record_value,
	input  logic [$clog2(NUM_BINS+2)-1:0]         bin_index,
	// Result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  diff_valid,
	output logic signed [EPOCH_BITS+CLOCK_BITS:0] delta_cycles,
	output logic [1:0]                            range_class,
	output logic [ctdh_pkg::COUNT_W-1:0]          bin_count
);
	import ctdh_pkg::*;

	localparam int DW    = EPOCH_BITS + CLOCK_BITS + 1;
	localparam int BIN_W = $clog2(NUM_BINS);
	localparam int IDX_W = $clog2(NUM_BINS + 2);

	// Configuration register; the user must write it only while the block is idle (not enforced).
	logic [HALF_W-1:0] half_q;

	// Stage one: the accepted request.
	logic              valid_s1;
	logic [1:0]        action_s1;
	logic [31:0]       code_s1, value_s1;
	logic [IDX_W-1:0]  index_s1;

	// Stage two: the result register.
	logic              valid_s2;
	logic              diff_valid_s2;
	logic [DW-1:0]     diff_s2;
	logic [1:0]        class_s2;

	logic              adv, in_fire, out_fire, move_s1;

	logic              tu_diff_valid;
	logic signed [DW-1:0] tu_diff;
	logic [1:0]        tu_class;
	cnt_sel_t          tu_bump;
	logic [BIN_W-1:0]  tu_bump_addr;
	cnt_sel_t          rd_sel;
	hist_op_t          op_s1;

	// Stage two advances when empty or when its result is taken; stage one
	// refills when empty or moving on, so a waiting result blocks intake only
	// while stage one also holds a request.
	assign cfg_ready = 1'b1;
	assign adv       = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || adv;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = valid_s2 && out_ready;
	assign move_s1   = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RANGE_RESET;
		end else if (cfg_valid) begin
			half_q <= half_range_cycles;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_fire) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Hold the request payload in stage one.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1 <= action;
			code_s1   <= record_code;
			value_s1  <= record_value;
			index_s1  <= bin_index;
		end
	end

	ctdh_time_unit #(
		.NUM_BINS   (NUM_BINS),
		.EPOCH_BITS (EPOCH_BITS),
		.CLOCK_BITS (CLOCK_BITS)
	) u_time (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (move_s1),
		.action       (action_s1),
		.record_code  (code_s1),
		.record_value (value_s1),
		.half_range   (half_q),
		.diff_valid   (tu_diff_valid),
		.delta_cycles (tu_diff),
		.range_class  (tu_class),
		.bump         (tu_bump),
		.bump_addr    (tu_bump_addr)
	);

	// Decode a bin read: regular bins, then underflow, then overflow.
	always_comb begin
		rd_sel = SEL_NONE;
		if (action_s1 == ACT_READ) begin
			if (index_s1 < IDX_W'(NUM_BINS)) begin
				rd_sel = SEL_BIN;
			end else if (index_s1 == IDX_W'(NUM_BINS)) begin
				rd_sel = SEL_UNDER;
			end else if (index_s1 == IDX_W'(NUM_BINS + 1)) begin
				rd_sel = SEL_OVER;
			end
		end
		op_s1.bump  = tu_bump;
		op_s1.rd    = rd_sel;
		op_s1.clear = (action_s1 == ACT_CLEAR);
	end

	ctdh_hist #(
		.NUM_BINS (NUM_BINS)
	) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (move_s1),
		.fire      (out_fire),
		.op        (op_s1),
		.bump_addr (tu_bump_addr),
		.rd_addr   (index_s1[BIN_W-1:0]),
		.bin_count (bin_count)
	);

	// Result register for the difference fields.
	always_ff @(posedge clk) begin
		if (move_s1) begin
			diff_valid_s2 <= tu_diff_valid;
			diff_s2       <= tu_diff;
			class_s2      <= tu_class;
		end
	end

	assign out_valid    = valid_s2;
	assign diff_valid   = diff_valid_s2;
	assign delta_cycles = $signed(diff_s2);
	assign range_class  = class_s2;

	// A request taken while a result waits must land in stage one.
	`CTDH_ASSERT_NEXT(a_no_drop, in_valid && in_ready && out_valid && !out_ready, out_valid && valid_s1, "request lost behind a stalled result")
	// Without a difference the difference fields are zero.
	`CTDH_ASSERT_IMPLIES(a_idle_diff, out_valid && !diff_valid, range_class == CLS_IN && delta_cycles == '0, "stale difference fields")
	// A difference and a bin read never share one result.
	`CTDH_ASSERT_IMPLIES(a_diff_no_count, out_valid && diff_valid, bin_count == '0, "bin count on a trigger result")

endmodule

### bench/coincidence_time_difference_histogram_tb.sv
// Self-checking bench for the coincidence time-difference histogram: directed and random records.
`timescale 1ns / 1ps

module coincidence_time_difference_histogram_tb;
	import ctdh_pkg::*;

	localparam int NUM_BINS    = 64;
	localparam int EPOCH_BITS  = 16;
	localparam int CLOCK_BITS  = 30;
	localparam int STAMP_W     = EPOCH_BITS + CLOCK_BITS;
	localparam int DIFF_W      = STAMP_W + 1;
	localparam int IDX_W       = $clog2(NUM_BINS + 2);
	localparam int UNDER_IDX   = NUM_BINS;
	localparam int OVER_IDX    = NUM_BINS + 1;
	localparam int IDX_TOP     = (1 << IDX_W) - 1;
	localparam int CLOCK_TOP   = (1 << CLOCK_BITS) - 1;
	localparam int EPOCH_TOP   = (1 << EPOCH_BITS) - 1;
	// Spare action code: the block must ignore it.
	localparam logic [1:0] ACT_SPARE = 2'd3;

	// Random traffic ends here; the quiet tail and the final readout follow.
	localparam int QUIET_START = 480;
	localparam int TOTAL_ITEMS = 600;
	localparam int CYCLE_LIMIT = 300000;

	typedef struct {
		logic                     dv;
		logic signed [DIFF_W-1:0] diff;
		logic [1:0]               cls;
		logic [COUNT_W-1:0]       count;
	} hist_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [HALF_W-1:0]     half_range_cycles = HALF_RANGE_RESET;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            action = ACT_RECORD;
	logic [31:0]           record_code = '0;
	logic [31:0]           record_value = '0;
	logic [IDX_W-1:0]      bin_index = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b1;
	logic                  diff_valid;
	logic signed [DIFF_W-1:0] delta_cycles;
	logic [1:0]            range_class;
	logic [COUNT_W-1:0]    bin_count;

	// Predictor state: our own copy of what the block should hold.
	logic [HALF_W-1:0]     range_setting;
	logic [EPOCH_BITS-1:0] epoch_now;
	logic [STAMP_W-1:0]    stamp_a;
	logic [STAMP_W-1:0]    stamp_b;
	logic                  stamp_a_ok;
	logic                  stamp_b_ok;
	logic [COUNT_W-1:0]    bin_tally [NUM_BINS];
	logic [COUNT_W-1:0]    under_tally;
	logic [COUNT_W-1:0]    over_tally;

	hist_result_t expected_results[$];
	int mismatch_count = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;

	coincidence_time_difference_histogram #(
		.NUM_BINS  (NUM_BINS),
		.EPOCH_BITS(EPOCH_BITS),
		.CLOCK_BITS(CLOCK_BITS)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.half_range_cycles(half_range_cycles),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.record_code      (record_code),
		.record_value     (record_value),
		.bin_index        (bin_index),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.diff_valid       (diff_valid),
		.delta_cycles     (delta_cycles),
		.range_class      (range_class),
		.bin_count        (bin_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				expected_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [COUNT_W-1:0] saturating_inc(input logic [COUNT_W-1:0] c);
		return (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction

	// Clear the predicted histogram, as a clear request or reset does.
	function automatic void wipe_tallies();
		for (int i = 0; i < NUM_BINS; i++)
			bin_tally[i] = '0;
		under_tally = '0;
		over_tally = '0;
	endfunction

	// Advance the predicted state by one request and return the result it must produce.
	function automatic hist_result_t predict_histogram(input logic [1:0] act,
			input logic [31:0] code, input logic [31:0] value, input logic [IDX_W-1:0] idx);
		hist_result_t r;
		logic [31:0] epoch_raw;
		logic [STAMP_W-1:0] t;
		logic [STAMP_W-1:0] mag;
		logic neg;
		int slot;
		r = '{dv: 1'b0, diff: '0, cls: CLS_IN, count: '0};
		if (act == ACT_RECORD) begin
			if (code == MARKER_CODE) begin
				epoch_raw = value - MARKER_CODE;
				epoch_now = epoch_raw[EPOCH_BITS-1:0];
			end else begin
				// Upper bits of the clock column are dropped.
				t = {epoch_now, value[CLOCK_BITS-1:0]};
				if (code == MASK_A || code == MASK_AB) begin
					stamp_a = t;
					stamp_a_ok = 1'b1;
				end
				if (code == MASK_B || code == MASK_AB) begin
					stamp_b = t;
					stamp_b_ok = 1'b1;
				end
				if (code == MASK_TRIG && stamp_a_ok && stamp_b_ok) begin
					r.dv = 1'b1;
					r.diff = {1'b0, stamp_b} - {1'b0, stamp_a};
					neg = stamp_b < stamp_a;
					mag = neg ? stamp_a - stamp_b : stamp_b - stamp_a;
					if (mag > range_setting) begin
						if (neg) begin
							r.cls = CLS_UNDER;
							under_tally = saturating_inc(under_tally);
						end else begin
							r.cls = CLS_OVER;
							over_tally = saturating_inc(over_tally);
						end
					end else begin
						slot = neg ? int'(range_setting) - int'(mag)
						           : int'(range_setting) + int'(mag);
						// A slot past the array end counts as overflow.
						if (slot < NUM_BINS) begin
							r.cls = CLS_IN;
							bin_tally[slot] = saturating_inc(bin_tally[slot]);
						end else begin
							r.cls = CLS_OVER;
							over_tally = saturating_inc(over_tally);
						end
					end
				end
			end
		end else if (act == ACT_READ) begin
			if (idx < NUM_BINS)
				r.count = bin_tally[idx];
			else if (idx == UNDER_IDX)
				r.count = under_tally;
			else if (idx == OVER_IDX)
				r.count = over_tally;
		end else if (act == ACT_CLEAR) begin
			wipe_tallies();
		end
		return r;
	endfunction

	// Compare each delivered result against the oldest prediction.
	always @(posedge clk) begin : check_result
		hist_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got dv=%0b diff=%0d cls=%0d cnt=%0d",
					$time, diff_valid, delta_cycles, range_class, bin_count);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (diff_valid !== want.dv) begin
					$display("%0t: diff_valid expected %0b got %0b", $time, want.dv, diff_valid);
					mismatch_count++;
				end
				if (delta_cycles !== want.diff) begin
					$display("%0t: delta_cycles expected %0d got %0d", $time, want.diff,
						delta_cycles);
					mismatch_count++;
				end
				if (range_class !== want.cls) begin
					$display("%0t: range_class expected %0d got %0d", $time, want.cls,
						range_class);
					mismatch_count++;
				end
				if (bin_count !== want.count) begin
					$display("%0t: bin_count expected %0d got %0d", $time, want.count,
						bin_count);
					mismatch_count++;
				end
			end
		end
	end

	// Randomly drop out_ready in bursts to back-pressure the result side.
	always begin
		@(posedge clk);
		if (arst_n && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
			out_ready <= 1'b1;
		end
	end

	// Present one request, hold it until accepted, then record its prediction.
	// Valid stays high on return so a following request goes out back to back.
	task automatic send_request(input logic [1:0] act, input logic [31:0] code,
			input logic [31:0] value, input logic [IDX_W-1:0] idx);
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		record_code <= code;
		record_value <= value;
		bin_index <= idx;
		do
			@(posedge clk);
		while (!in_ready);
		expected_results.push_back(predict_histogram(act, code, value, idx));
		items_sent++;
	endtask

	task automatic send_record(input logic [31:0] code, input logic [31:0] value);
		send_request(ACT_RECORD, code, value, IDX_W'($urandom_range(0, IDX_TOP)));
	endtask

	task automatic send_read(input int idx);
		send_request(ACT_READ, $urandom, $urandom, IDX_W'(idx));
	endtask

	// Drop valid and hold off until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_half_range(input logic [HALF_W-1:0] setting);
		drain_results();
		cfg_valid <= 1'b1;
		half_range_cycles <= setting;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		range_setting = setting;
	endtask

	// Put junk in the clock column bits above the counter.
	function automatic logic [31:0] noisy_clock(input logic [CLOCK_BITS-1:0] c);
		return {2'($urandom_range(0, 3)), c};
	endfunction

	// Latch A and B a given number of cycles apart, then trigger.
	task automatic send_coincidence(input int offset);
		logic [CLOCK_BITS-1:0] base;
		logic [CLOCK_BITS-1:0] other;
		base = CLOCK_BITS'($urandom_range(64, CLOCK_TOP - 64));
		other = base + CLOCK_BITS'(offset);
		if (offset == 0 && $urandom_range(0, 1)) begin
			send_record(MASK_AB, noisy_clock(base));
		end else if ($urandom_range(0, 1)) begin
			send_record(MASK_A, noisy_clock(base));
			send_record(MASK_B, noisy_clock(other));
		end else begin
			send_record(MASK_B, noisy_clock(other));
			send_record(MASK_A, noisy_clock(base));
		end
		send_record(MASK_TRIG, $urandom);
	endtask

	// Read back every bin plus the underflow and overflow counters.
	task automatic read_histogram();
		for (int i = 0; i <= OVER_IDX; i++)
			send_read(i);
	endtask

	// One random burst: mostly well-formed coincidences, with reads, clears and junk.
	task automatic random_sequence();
		int kind;
		int reach;
		int k;
		logic [EPOCH_BITS-1:0] e;
		kind = $urandom_range(0, 99);
		reach = int'(range_setting) + 3;
		if (kind < 55) begin
			if ($urandom_range(0, 3) == 0)
				send_record(MARKER_CODE, $urandom);
			send_coincidence($urandom_range(0, 2 * reach) - reach);
			// Extra triggers reuse the latched stamps.
			if ($urandom_range(0, 4) == 0)
				send_record(MASK_TRIG, $urandom);
		end else if (kind < 65) begin
			// A late in one epoch, B early in the next.
			e = EPOCH_BITS'($urandom_range(0, EPOCH_TOP - 1));
			k = $urandom_range(0, 15);
			send_record(MARKER_CODE, MARKER_CODE + 32'(e));
			send_record(MASK_A, noisy_clock(CLOCK_BITS'(CLOCK_TOP - 15 + k)));
			send_record(MARKER_CODE, MARKER_CODE + 32'(e) + 32'd1);
			send_record(MASK_B, noisy_clock(CLOCK_BITS'($urandom_range(0, 15))));
			send_record(MASK_TRIG, $urandom);
		end else if (kind < 77) begin
			if ($urandom_range(0, 3) == 0)
				send_read($urandom_range(0, IDX_TOP));
			else
				send_read($urandom_range(0, OVER_IDX));
		end else if (kind < 80) begin
			send_request(ACT_CLEAR, $urandom, $urandom, IDX_W'($urandom_range(0, IDX_TOP)));
		end else if (kind < 97) begin
			case ($urandom_range(0, 2))
				0: k = $urandom;
				1: k = $urandom_range(0, 7);
				default: k = MARKER_CODE;
			endcase
			send_request(2'($urandom_range(0, 3)), 32'(k), $urandom,
				IDX_W'($urandom_range(0, IDX_TOP)));
		end else begin
			// Hold the sender off until everything in flight has come back.
			drain_results();
		end
	endtask

	task automatic test_directed_records();
		// Trigger with nothing latched yet gives no difference.
		send_record(MASK_TRIG, 32'd0);
		send_read(UNDER_IDX);
		send_read(OVER_IDX);
		send_read(IDX_TOP);
		send_record(MARKER_CODE, MARKER_CODE + 32'd3);
		send_record(MASK_A, 32'hC000_0010);
		// Only A valid: still no difference.
		send_record(MASK_TRIG, 32'hFFFF_FFFF);
		send_record(MASK_B, 32'h0000_0015);
		send_record(MASK_TRIG, 32'd0);
		// Stamps are kept after a trigger.
		send_record(MASK_TRIG, 32'd0);
		send_record(MASK_AB, 32'h3FFF_FFFF);
		send_record(MASK_TRIG, 32'd0);
		// Marker value below the marker code wraps to the top epoch.
		send_record(MARKER_CODE, 32'h7FFF_FFFF);
		send_record(MASK_B, 32'hFFFF_FFFF);
		send_record(MASK_TRIG, 32'd0);
		send_record(MARKER_CODE, 32'h0000_1234);
		send_record(MASK_A, 32'd7);
		send_record(MARKER_CODE, MARKER_CODE);
		send_record(MASK_B, 32'd0);
		send_record(MASK_TRIG, 32'd0);
		// Masks that mean nothing, and the spare action.
		send_record(32'd0, 32'hFFFF_FFFF);
		send_record(32'd5, 32'd0);
		send_request(ACT_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, IDX_W'(IDX_TOP));
		send_read(25);
		send_request(ACT_CLEAR, 32'd0, 32'd0, '0);
		send_read(OVER_IDX);
	endtask

	task automatic test_range_extremes();
		write_half_range('0);
		send_coincidence(0);
		send_coincidence(1);
		send_coincidence(-1);
		send_read(0);
		send_read(UNDER_IDX);
		send_read(OVER_IDX);
		write_half_range('1);
		send_coincidence(31);
		send_coincidence(-31);
		send_coincidence(32);
		send_coincidence(-32);
		send_read(2 * 31);
		send_read(0);
		send_read(NUM_BINS - 1);
		read_histogram();
		write_half_range(HALF_RANGE_RESET);
	endtask

	task automatic test_random_traffic();
		int phase;
		int phase_end;
		phase = 0;
		while (items_sent < QUIET_START) begin
			case (phase % 4)
				0: write_half_range('0);
				1: write_half_range('1);
				default: write_half_range(HALF_W'($urandom_range(0, 31)));
			endcase
			// Some phases run with no idling at all.
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 8;
				default: gap_pct = 30;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 8;
				default: stall_pct = 30;
			endcase
			phase_end = items_sent + 110;
			while (items_sent < phase_end && items_sent < QUIET_START)
				random_sequence();
			phase++;
		end
	endtask

	// Full-rate tail with no idling on either side, then a complete readout.
	task automatic test_quiet_tail();
		gap_pct = 0;
		stall_pct = 0;
		write_half_range(HALF_W'($urandom_range(0, 31)));
		while (items_sent < TOTAL_ITEMS)
			random_sequence();
		read_histogram();
	endtask

	initial begin
		range_setting = HALF_RANGE_RESET;
		epoch_now = '0;
		stamp_a = '0;
		stamp_b = '0;
		stamp_a_ok = 1'b0;
		stamp_b_ok = 1'b0;
		wipe_tallies();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		gap_pct = 10;
		stall_pct = 10;
		test_directed_records();
		test_range_extremes();
		test_random_traffic();
		test_quiet_tail();
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/ctdh_pkg.sv
rtl/ctdh_time_unit.sv
rtl/ctdh_hist.sv
rtl/coincidence_time_difference_histogram.sv
bench/coincidence_time_difference_histogram_tb.sv
